/* design/assert_macros.svh */
// shared assertion macros for the smoother checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define TVS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TVS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/tvs_pkg.sv */
package tvs_pkg;

  localparam int POS_W     = 32;  // coordinate port width
  localparam int OFF_W     = 33;  // neighbor minus vertex, exact
  localparam int CSUM_W    = 40;  // centroid accumulator
  localparam int NSUM_W    = 64;  // area normal accumulator
  localparam int NORM_BITS = 29;  // normal magnitudes are brought below 2^29
  localparam int MUL_W     = 33;  // shared multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_W     = 96;  // divider dividend and quotient width
  localparam int DEN_W     = 64;  // divider divisor width
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int AVG_W     = 33;  // centroid component
  localparam int D_W       = 34;  // centroid minus vertex
  localparam int RES_W     = 66;  // result before saturation

  typedef enum logic [1:0] {
    ST_NORMAL      = 2'd0,
    ST_ZERO_NORMAL = 2'd1,
    ST_OVERFLOW    = 2'd2
  } status_t;

endpackage

/* design/tvs_if.sv */
interface tvs_in_if;
  import tvs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] center_x;
  logic signed [POS_W-1:0] center_y;
  logic signed [POS_W-1:0] center_z;
  logic signed [POS_W-1:0] neighbor_x;
  logic signed [POS_W-1:0] neighbor_y;
  logic signed [POS_W-1:0] neighbor_z;
  logic                    first_neighbor;
  logic                    last_neighbor;

  modport source (output valid, center_x, center_y, center_z, neighbor_x, neighbor_y,
                  neighbor_z, first_neighbor, last_neighbor, input ready);
  modport sink (input valid, center_x, center_y, center_z, neighbor_x, neighbor_y,
                neighbor_z, first_neighbor, last_neighbor, output ready);
endinterface

interface tvs_out_if;
  import tvs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] smoothed_x;
  logic signed [POS_W-1:0] smoothed_y;
  logic signed [POS_W-1:0] smoothed_z;
  status_t                 status;

  modport source (output valid, smoothed_x, smoothed_y, smoothed_z, status, input ready);
  modport sink (input valid, smoothed_x, smoothed_y, smoothed_z, status, output ready);
endinterface

/* design/tvs_mul.sv */
module tvs_mul (
  input  logic                         clk,
  input  logic [tvs_pkg::MUL_W-1:0]    a,
  input  logic [tvs_pkg::MUL_W-1:0]    b,
  output logic [tvs_pkg::PROD_W-1:0]   prod
);
  import tvs_pkg::*;

  // unsigned magnitude product, registered
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* design/tvs_div.sv */
module tvs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tvs_pkg::DIV_W-1:0]   dividend,
  input  logic [tvs_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [tvs_pkg::DIV_W-1:0]   quotient
);
  import tvs_pkg::*;

  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     dvs;
  logic [DIV_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 fits;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem, quo[DIV_W-1]};
    fits    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* design/tangential_vertex_smoother.sv */
// channel  | role   | carries
// in_ch    | sink   | vertex position, one fan neighbor, first and last marks
// out_ch   | source | smoothed position and status, one per closing neighbor
//
// an item that is not last returns to idle after its neighbor step, and after summing a
// cross product on the shared multiplier when one is due; the last item adds the closing
// cross product, normalizing shifts, three centroid runs of the divider and, unless the
// normal is zero, three projection runs
// synchronous active-high reset clears the sequencer, the neighbor count and the output
// a result waiting on out_ch holds the block only when the next result is ready to leave
module tangential_vertex_smoother #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int FRAC_BITS     = 24,
  parameter int COORD_BITS    = 32
) (
  input  logic      clk,
  input  logic      rst,
  tvs_in_if.sink    in_ch,
  tvs_out_if.source out_ch
);
  import tvs_pkg::*;

  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam int SH    = POS_W - COORD_BITS;
  localparam logic signed [RES_W-1:0] SAT_HI =
    $signed((RES_W'(1) << (COORD_BITS - 1)) - RES_W'(1));
  localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_NB    = 14'h0002,
    S_XMUL  = 14'h0004,
    S_XACC  = 14'h0008,
    S_NLOAD = 14'h0010,
    S_NORM  = 14'h0020,
    S_CDIV  = 14'h0040,
    S_CWAIT = 14'h0080,
    S_DMUL  = 14'h0100,
    S_DACC  = 14'h0200,
    S_PMUL  = 14'h0400,
    S_PACC  = 14'h0800,
    S_PWAIT = 14'h1000,
    S_OUT   = 14'h2000
  } state_t;

  state_t                   state;
  logic signed [POS_W-1:0]  vp [3];
  logic signed [POS_W-1:0]  nb [3];
  logic                     last_r;
  logic signed [CSUM_W-1:0] csum [3];
  logic [NSUM_W-1:0]        nsum [3];
  logic signed [OFF_W-1:0]  first_off [3];
  logic signed [OFF_W-1:0]  prev_off [3];
  logic signed [OFF_W-1:0]  cur_off [3];
  logic [CNT_W-1:0]         count;
  logic                     ovf;
  logic                     closing;
  logic [2:0]               step;
  logic [1:0]               comp;
  logic [NSUM_W-1:0]        nmag [3];
  logic                     nneg [3];
  logic signed [AVG_W-1:0]  avg [3];
  logic signed [D_W-1:0]    dv [3];
  logic [NSUM_W-1:0]        num;
  logic [DEN_W-1:0]         den;
  logic [PROD_W-1:0]        plo;
  logic signed [POS_W-1:0]  res [3];

  logic                     out_valid;
  logic signed [POS_W-1:0]  out_x, out_y, out_z;
  status_t                  out_status;

  logic                     in_acc;
  logic                     open_v;
  logic signed [OFF_W-1:0]  xa, xb;
  logic signed [OFF_W-1:0]  bsel [3];
  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        ps_full;
  logic [NSUM_W-1:0]        xterm;
  logic                     xneg;
  logic [1:0]               ncomp;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dvd;
  logic [DEN_W-1:0]         div_dvs;
  logic                     div_done;
  logic [DIV_W-1:0]         div_q;
  logic [NSUM_W-1:0]        num_mag;
  logic [MUL_W-1:0]         nr_mag;
  logic [MUL_W-1:0]         d_mag;
  logic [CSUM_W-1:0]        csum_mag;
  logic [DIV_W-1:0]         pbig;
  logic signed [AVG_W-1:0]  avg_new;
  logic signed [RES_W-1:0]  proj;
  logic signed [RES_W-1:0]  rv;
  logic signed [RES_W-1:0]  rsat;
  logic signed [RES_W-1:0]  asat;
  logic                     big;
  logic                     out_free;

  function automatic logic signed [POS_W-1:0] sext(input logic [POS_W-1:0] raw);
    return $signed(raw << SH) >>> SH;
  endfunction

  function automatic logic [MUL_W-1:0] mag_off(input logic signed [OFF_W-1:0] v);
    logic signed [OFF_W-1:0] n;
    n = -v;
    return MUL_W'(v[OFF_W-1] ? n : v);
  endfunction

  function automatic logic signed [RES_W-1:0] sat(input logic signed [RES_W-1:0] v);
    return (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
  endfunction

  tvs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  tvs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quotient(div_q)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign open_v      = in_ch.first_neighbor || (count == '0);
  assign out_free    = !out_valid || out_ch.ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bsel[k] = closing ? first_off[k] : cur_off[k];
    end
    // cross product term for this step: a x b, even steps add, odd steps subtract
    case (step)
      3'd0:    begin xa = prev_off[1]; xb = bsel[2]; end
      3'd1:    begin xa = prev_off[2]; xb = bsel[1]; end
      3'd2:    begin xa = prev_off[2]; xb = bsel[0]; end
      3'd3:    begin xa = prev_off[0]; xb = bsel[2]; end
      3'd4:    begin xa = prev_off[0]; xb = bsel[1]; end
      default: begin xa = prev_off[1]; xb = bsel[0]; end
    endcase
    ncomp   = step[2:1];
    ps_full = prod >> FRAC_BITS;
    xterm   = ps_full[NSUM_W-1:0];
    xneg    = xa[OFF_W-1] ^ xb[OFF_W-1] ^ step[0];

    num_mag  = num[NSUM_W-1] ? -num : num;
    nr_mag   = nmag[comp][MUL_W-1:0];
    d_mag    = MUL_W'(dv[comp][D_W-1] ? -dv[comp] : dv[comp]);
    csum_mag = csum[comp][CSUM_W-1] ? -csum[comp] : csum[comp];
    pbig     = DIV_W'(plo) + (DIV_W'(prod) << 32);
    avg_new  = csum[comp][CSUM_W-1] ? -$signed(div_q[AVG_W-1:0])
                                    : $signed(div_q[AVG_W-1:0]);
    proj     = $signed({3'b000, div_q[62:0]});
    if (num[NSUM_W-1] ^ nneg[comp]) begin
      proj = -proj;
    end
    rv   = RES_W'(avg[comp]) - proj;
    rsat = sat(rv);
    asat = sat(RES_W'(avg[comp]));

    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (nmag[k][NSUM_W-1:NORM_BITS] != '0) begin
        big = 1'b1;
      end
    end

    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state)
      S_XMUL: begin
        mul_a = mag_off(xa);
        mul_b = mag_off(xb);
      end
      S_DMUL: begin
        mul_a = step[0] ? nr_mag : d_mag;
        mul_b = nr_mag;
      end
      S_PMUL: begin
        mul_a = MUL_W'(step[0] ? num_mag[63:32] : num_mag[31:0]);
        mul_b = nr_mag;
      end
      S_CDIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(csum_mag);
        div_dvs   = DEN_W'(count);
      end
      S_PACC: begin
        div_start = step[0];
        div_dvd   = pbig;
        div_dvs   = den;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      closing   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            nb[0]   <= sext(in_ch.neighbor_x);
            nb[1]   <= sext(in_ch.neighbor_y);
            nb[2]   <= sext(in_ch.neighbor_z);
            last_r  <= in_ch.last_neighbor;
            closing <= 1'b0;
            if (open_v) begin
              vp[0] <= sext(in_ch.center_x);
              vp[1] <= sext(in_ch.center_y);
              vp[2] <= sext(in_ch.center_z);
              for (int k = 0; k < 3; k++) begin
                csum[k]      <= '0;
                nsum[k]      <= '0;
                first_off[k] <= '0;
                prev_off[k]  <= '0;
              end
              count <= '0;
              ovf   <= 1'b0;
            end
            state <= S_NB;
          end
        end
        S_NB: begin
          if (count < CNT_W'(MAX_NEIGHBORS)) begin
            for (int k = 0; k < 3; k++) begin
              csum[k] <= csum[k] + CSUM_W'(nb[k]);
            end
            count <= count + 1'b1;
            if (count == '0) begin
              for (int k = 0; k < 3; k++) begin
                first_off[k] <= OFF_W'(nb[k]) - OFF_W'(vp[k]);
                prev_off[k]  <= OFF_W'(nb[k]) - OFF_W'(vp[k]);
              end
              state <= last_r ? S_XMUL : S_IDLE;
              closing <= last_r;
              step <= '0;
            end else begin
              for (int k = 0; k < 3; k++) begin
                cur_off[k] <= OFF_W'(nb[k]) - OFF_W'(vp[k]);
              end
              step  <= '0;
              state <= S_XMUL;
            end
          end else begin
            ovf     <= 1'b1;
            closing <= last_r;
            step    <= '0;
            state   <= last_r ? S_XMUL : S_IDLE;
          end
        end
        S_XMUL: begin
          state <= S_XACC;
        end
        S_XACC: begin
          nsum[ncomp] <= xneg ? nsum[ncomp] - xterm : nsum[ncomp] + xterm;
          if (step == 3'd5) begin
            step <= '0;
            if (closing) begin
              state <= S_NLOAD;
            end else begin
              for (int k = 0; k < 3; k++) begin
                prev_off[k] <= cur_off[k];
              end
              closing <= last_r;
              state   <= last_r ? S_XMUL : S_IDLE;
            end
          end else begin
            step  <= step + 1'b1;
            state <= S_XMUL;
          end
        end
        S_NLOAD: begin
          for (int k = 0; k < 3; k++) begin
            nmag[k] <= nsum[k][NSUM_W-1] ? -nsum[k] : nsum[k];
            nneg[k] <= nsum[k][NSUM_W-1];
          end
          state <= S_NORM;
        end
        S_NORM: begin
          // common right shift until every magnitude is below 2^29
          if (big) begin
            for (int k = 0; k < 3; k++) begin
              nmag[k] <= nmag[k] >> 1;
            end
          end else begin
            comp  <= '0;
            state <= S_CDIV;
          end
        end
        S_CDIV: begin
          state <= S_CWAIT;
        end
        S_CWAIT: begin
          if (div_done) begin
            avg[comp] <= avg_new;
            dv[comp]  <= D_W'(avg_new) - D_W'(vp[comp]);
            if (comp == 2'd2) begin
              comp  <= '0;
              step  <= '0;
              num   <= '0;
              den   <= '0;
              state <= S_DMUL;
            end else begin
              comp  <= comp + 1'b1;
              state <= S_CDIV;
            end
          end
        end
        S_DMUL: begin
          state <= S_DACC;
        end
        S_DACC: begin
          if (step[0]) begin
            den  <= den + prod[DEN_W-1:0];
            step <= '0;
            if (comp == 2'd2) begin
              comp  <= '0;
              state <= S_PMUL;
            end else begin
              comp  <= comp + 1'b1;
              state <= S_DMUL;
            end
          end else begin
            num   <= (dv[comp][D_W-1] ^ nneg[comp]) ? num - prod[NSUM_W-1:0]
                                                    : num + prod[NSUM_W-1:0];
            step  <= 3'd1;
            state <= S_DMUL;
          end
        end
        S_PMUL: begin
          if (den == '0) begin
            res[comp] <= POS_W'(asat);
            step      <= '0;
            if (comp == 2'd2) begin
              state <= S_OUT;
            end else begin
              comp <= comp + 1'b1;
            end
          end else begin
            state <= S_PACC;
          end
        end
        S_PACC: begin
          if (step[0]) begin
            state <= S_PWAIT;
          end else begin
            plo   <= prod;
            step  <= 3'd1;
            state <= S_PMUL;
          end
        end
        S_PWAIT: begin
          if (div_done) begin
            res[comp] <= POS_W'(rsat);
            step      <= '0;
            if (comp == 2'd2) begin
              state <= S_OUT;
            end else begin
              comp  <= comp + 1'b1;
              state <= S_PMUL;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_x      <= res[0];
            out_y      <= res[1];
            out_z      <= res[2];
            out_status <= ovf ? ST_OVERFLOW : ((den == '0) ? ST_ZERO_NORMAL : ST_NORMAL);
            count      <= '0;
            ovf        <= 1'b0;
            closing    <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.smoothed_x = out_x;
  assign out_ch.smoothed_y = out_y;
  assign out_ch.smoothed_z = out_z;
  assign out_ch.status     = out_status;

endmodule

/* design/tvs_checker.sv */
`include "assert_macros.svh"

module tvs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [tvs_pkg::POS_W-1:0] out_x,
  input logic signed [tvs_pkg::POS_W-1:0] out_y,
  input logic signed [tvs_pkg::POS_W-1:0] out_z,
  input logic [1:0]                  out_status
);
  import tvs_pkg::*;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // ready is low in the cycle after an accept, so no transaction follows another back to back
  `TVS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_acc, !in_ready, "ready right after accept")
  `TVS_ASSERT_NEXT(a_out_held, clk, rst, out_stall, out_valid, "result dropped while stalled")
  `TVS_ASSERT_NEXT(a_out_stable, clk, rst, out_stall,
    $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_status),
    "result changed while stalled")
  `TVS_ASSERT_SAME(a_status_code, clk, rst, out_valid,
    out_status == ST_NORMAL || out_status == ST_ZERO_NORMAL || out_status == ST_OVERFLOW,
    "unknown status code")

endmodule

bind tangential_vertex_smoother tvs_checker u_tvs_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_x(out_ch.smoothed_x),
  .out_y(out_ch.smoothed_y),
  .out_z(out_ch.smoothed_z),
  .out_status(out_ch.status)
);
